>>> rtl/core/rsc_pkg.sv
`default_nettype none
package rsc_pkg;

  typedef logic [7:0] char_t;
  typedef logic [5:0] base_t;
  typedef logic [5:0] digit_t;

  // status from the iterative divider
  typedef struct packed {
    logic active;
    logic done;
  } div_stat_t;

  // configuration register indexes
  localparam logic CFG_IN_BASE  = 1'b0;
  localparam logic CFG_OUT_BASE = 1'b1;

  localparam base_t BASE_MIN       = 6'd2;
  localparam base_t BASE_MAX       = 6'd36;
  localparam base_t IN_BASE_RESET  = 6'd10;
  localparam base_t OUT_BASE_RESET = 6'd16;

  localparam char_t CHAR_NUL = 8'h00;
  localparam char_t CHAR_0   = 8'h30;
  localparam char_t CHAR_9   = 8'h39;
  localparam char_t CHAR_A   = 8'h41;
  localparam char_t CHAR_Z   = 8'h5A;
  localparam digit_t DIGIT_TEN = 6'd10;

  function automatic logic char_is_digit(char_t c);
    return ((c >= CHAR_0) && (c <= CHAR_9)) || ((c >= CHAR_A) && (c <= CHAR_Z));
  endfunction

  // value of a 0-9/A-Z character; zero for anything else
  function automatic digit_t char_to_digit(char_t c);
    digit_t d;
    d = '0;
    if ((c >= CHAR_0) && (c <= CHAR_9)) begin
      d = digit_t'(c - CHAR_0);
    end else if ((c >= CHAR_A) && (c <= CHAR_Z)) begin
      d = digit_t'(c - CHAR_A) + DIGIT_TEN;
    end
    return d;
  endfunction

  function automatic char_t digit_to_char(digit_t d);
    char_t c;
    if (d < DIGIT_TEN) begin
      c = CHAR_0 + char_t'(d);
    end else begin
      c = CHAR_A + char_t'(d - DIGIT_TEN);
    end
    return c;
  endfunction

  function automatic base_t clamp_base(base_t b);
    base_t r;
    r = b;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/rsc_ram.sv
`default_nettype none
module rsc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/rsc_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. Divisor is at most 36,
// so the remainder stays in a digit-wide register.
module rsc_divider #(
  parameter int WIDTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [WIDTH-1:0]      dividend,
  input  wire rsc_pkg::base_t        divisor,
  output logic      [WIDTH-1:0]      quotient,
  output rsc_pkg::digit_t            remainder,
  output rsc_pkg::div_stat_t         stat
);
  import rsc_pkg::*;

  localparam int CW = $clog2(WIDTH);

  logic [CW-1:0] bit_cnt;
  logic [6:0]    shifted;
  logic          fits;

  assign shifted = {remainder, quotient[WIDTH-1]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else if (start) begin
      stat.active <= 1'b1;
      stat.done   <= 1'b0;
    end else if (stat.active) begin
      stat.done   <= (bit_cnt == '0);
      stat.active <= (bit_cnt != '0);
    end else begin
      stat.done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      bit_cnt   <= CW'(WIDTH - 1);
    end else if (stat.active) begin
      bit_cnt <= bit_cnt - 1'b1;
      if (fits) begin
        remainder <= digit_t'(shifted - {1'b0, divisor});
        quotient  <= {quotient[WIDTH-2:0], 1'b1};
      end else begin
        remainder <= shifted[5:0];
        quotient  <= {quotient[WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/radix_string_converter.sv
`default_nettype none
// Radix string converter.
// Input: one ASCII digit per transaction (start high while busy low), most
// significant first, digit_last on the final one. Each digit folds into an
// ACC_WIDTH-bit accumulator as acc*in_base+digit (wrapping); bad characters
// set a sticky error and leave the accumulator alone.
// Config: cfg_we/cfg_index/cfg_data write in_base (index 0) or out_base
// (index 1); bases below 2 act as 2, above 36 as 36. Write only when idle.
// Output: out_valid strobes one cycle per character, most significant
// first, out_last on the final one. The receiver cannot stall; every
// strobe is a delivered transaction. An errored numeral gives one result:
// out_char 0, out_last 1, bad_digit 1.
// Sequencing: a non-final digit keeps busy high only while it is folded
// in. On the final digit the value is converted by a shared bit-serial
// divider, one division per output digit, with remainders kept in a
// small RAM; then each character is a RAM read, then an output.
// Only the MAX_OUT_DIGITS least significant digits are emitted.
// Reset (rst, synchronous): in_base 10, out_base 16, accumulator and error
// cleared, idle. The digit RAM is not cleared; it is always written first.
module radix_string_converter #(
  parameter int ACC_WIDTH      = 64,
  parameter int MAX_OUT_DIGITS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  // command channel
  input  wire logic           start,
  output logic                busy,
  input  wire rsc_pkg::char_t digit_char,
  input  wire logic           digit_last,
  // configuration
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire rsc_pkg::base_t cfg_data,
  // results
  output logic                out_valid,
  output rsc_pkg::char_t      out_char,
  output logic                out_last,
  output logic                bad_digit
);
  import rsc_pkg::*;

  localparam int AW = $clog2(MAX_OUT_DIGITS);
  localparam int CNTW = $clog2(MAX_OUT_DIGITS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]           state;
  base_t                in_base;
  base_t                out_base;
  logic [ACC_WIDTH-1:0] acc;
  logic                 err;
  char_t                lat_char;
  logic                 lat_last;
  logic [CNTW-1:0]      cnt;
  logic [CNTW-1:0]      cnt_next;
  logic [AW-1:0]        ptr;

  // multiply-add for the incoming digit
  logic                 ch_ok;
  logic [ACC_WIDTH+5:0] prod;
  logic [ACC_WIDTH-1:0] mac;

  // shared divider
  logic                 div_start;
  logic [ACC_WIDTH-1:0] div_in;
  logic [ACC_WIDTH-1:0] div_quo;
  digit_t               div_rem;
  div_stat_t            div_stat;

  // digit store
  logic   ram_we;
  digit_t ram_rdata;

  wire accept = start && !busy;
  assign busy = (state != S_IDLE);

  assign ch_ok = char_is_digit(lat_char);
  assign prod  = acc * clamp_base(in_base);
  assign mac   = prod[ACC_WIDTH-1:0] + ACC_WIDTH'(char_to_digit(lat_char));

  // first division on a clean final digit, next one on a nonzero quotient
  assign div_start = ((state == S_MAC) && lat_last && !err && ch_ok)
                  || ((state == S_DIV) && div_stat.done && (div_quo != '0));
  assign div_in    = (state == S_MAC) ? mac : div_quo;

  // digits beyond the store depth are dropped (most significant ones)
  assign ram_we   = (state == S_DIV) && div_stat.done
                 && (cnt < CNTW'(MAX_OUT_DIGITS));
  assign cnt_next = ram_we ? cnt + 1'b1 : cnt;

  rsc_divider #(
    .WIDTH(ACC_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .divisor  (clamp_base(out_base)),
    .quotient (div_quo),
    .remainder(div_rem),
    .stat     (div_stat)
  );

  rsc_ram #(
    .WIDTH($bits(digit_t)),
    .DEPTH(MAX_OUT_DIGITS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt[AW-1:0]),
    .wdata(div_rem),
    .raddr(ptr),
    .rdata(ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      in_base  <= IN_BASE_RESET;
      out_base <= OUT_BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_BASE:  in_base  <= cfg_data;
        CFG_OUT_BASE: out_base <= cfg_data;
        default:      in_base  <= in_base;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (accept) begin
      lat_char <= digit_char;
      lat_last <= digit_last;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc       <= '0;
      err       <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (!lat_last) begin
            if (ch_ok) begin
              acc <= mac;
            end else begin
              err <= 1'b1;
            end
            state <= S_IDLE;
          end else begin
            acc   <= '0;
            err   <= 1'b0;
            cnt   <= '0;
            if (err || !ch_ok) begin
              out_valid <= 1'b1;
              out_char  <= CHAR_NUL;
              out_last  <= 1'b1;
              bad_digit <= 1'b1;
              state     <= S_IDLE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            cnt <= cnt_next;
            if (div_quo == '0) begin
              ptr   <= AW'(cnt_next - 1'b1);
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_char  <= digit_to_char(ram_rdata);
          out_last  <= (ptr == '0);
          bad_digit <= 1'b0;
          if (ptr == '0) begin
            state <= S_IDLE;
          end else begin
            ptr   <= ptr - 1'b1;
            state <= S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // error result is always a single, final transaction
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_digit |-> out_last)
    else $error("error result without out_last");

  // digit count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNTW'(MAX_OUT_DIGITS))
    else $error("digit count overflow");

  // the divider only runs during conversion
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_stat.active |-> state == S_DIV)
    else $error("divider active outside conversion");

  // a clean result only follows an output state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_digit |-> $past(state) == S_OUT)
    else $error("result strobe from wrong state");

  // emitted characters are alphanumeric
  a_out_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_digit |-> char_is_digit(out_char))
    else $error("non-alphanumeric output character");

endmodule
`default_nettype wire
